// ===== rtl/tksi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksi_pkg
// Shared types and constants for the top-k sorted insert table.
// ----------------------------------------------------------------------------
package tksi_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int TAG_BITS_DEF = 64;
  localparam int CNT_W        = 5;
  localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 5'd10;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic [63:0]        tag;
    logic signed [31:0] key;
    logic [3:0]         slot_index;
  } in_item_t;

  typedef struct packed {
    logic               placed;
    logic [3:0]         position;
    logic [CNT_W-1:0]   entry_count;
    logic               read_valid;
    logic [63:0]        read_tag;
    logic signed [31:0] read_key;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
  } tksi_cmd_t;

endpackage

// ===== rtl/tksi_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksi_ctrl
// Controller: takes an item, runs the table update, and owns result valid.
// ----------------------------------------------------------------------------
module tksi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output tksi_pkg::tksi_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  always_comb begin
    cmd.load = (state_r == ST_IDLE) && in_valid;
    cmd.exec = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) state_r <= ST_EXEC;
          if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
        end
        ST_EXEC: begin
          if (cmd.exec) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/tksi_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksi_dpath
// Datapath: row of sorted compare-and-shift cells, limit register, result.
// ----------------------------------------------------------------------------
module tksi_dpath #(
  parameter int CAPACITY = tksi_pkg::CAPACITY_DEF,
  parameter int TAG_BITS = tksi_pkg::TAG_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tksi_pkg::tksi_cmd_t  cmd,
  input  tksi_pkg::in_item_t   in_data,
  input  logic                 cfg_valid,
  input  logic [tksi_pkg::CNT_W-1:0] cfg_data,
  output tksi_pkg::out_item_t  out_data
);

  localparam int CNT_W = tksi_pkg::CNT_W;
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  tksi_pkg::in_item_t  item_r;
  tksi_pkg::out_item_t res_r;
  logic [TAG_BITS-1:0] tags_r [CAPACITY];
  logic signed [31:0]  keys_r [CAPACITY];
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    max_r;

  logic [CAPACITY-1:0] gt;
  logic [CNT_W-1:0]    limit;
  logic [CNT_W-1:0]    pos;
  logic [CNT_W-1:0]    n_new;
  logic                key_nz;
  logic                placed;
  logic                do_ins;
  logic                rd_ok;
  logic [IDX_W-1:0]    rd_idx;
  logic [CNT_W-1:0]    count_nxt;
  tksi_pkg::out_item_t res_nxt;

  always_comb begin
    limit = (int'(max_r) < CAPACITY) ? max_r : CNT_W'(CAPACITY);
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = (i < int'(count_r)) && (item_r.key < keys_r[i]);
    end
    pos = count_r;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!gt[i] && (i < int'(count_r))) pos = CNT_W'(i);
    end
    n_new  = (count_r < limit) ? count_r + 1'b1 : count_r;
    key_nz = (item_r.key != 32'sd0);
    placed = (item_r.operation == tksi_pkg::OP_INSERT) && key_nz && (pos < n_new);
    do_ins = cmd.exec && placed;

    count_nxt = count_r;
    if ((item_r.operation == tksi_pkg::OP_INSERT) && key_nz) count_nxt = n_new;

    rd_ok  = ({1'b0, item_r.slot_index} < count_r);
    rd_idx = IDX_W'(item_r.slot_index);

    res_nxt             = '0;
    res_nxt.entry_count = count_nxt;
    if (item_r.operation == tksi_pkg::OP_INSERT) begin
      res_nxt.placed   = placed;
      res_nxt.position = placed ? 4'(pos) : 4'd0;
    end else if (rd_ok) begin
      res_nxt.read_valid = 1'b1;
      res_nxt.read_tag   = 64'(tags_r[rd_idx]);
      res_nxt.read_key   = keys_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      max_r   <= tksi_pkg::MAX_ENTRIES_RST;
    end else begin
      if (cfg_valid) max_r <= cfg_data;
      if (cmd.exec) count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.exec) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (do_ins) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (i == int'(pos)) begin
          tags_r[i] <= TAG_BITS'(item_r.tag);
          keys_r[i] <= item_r.key;
        end else if ((i > int'(pos)) && (i > 0)) begin
          tags_r[i] <= tags_r[i-1];
          keys_r[i] <= keys_r[i-1];
        end
      end
    end
  end

  assign out_data = res_r;

endmodule

// ===== rtl/top_k_sorted_insert_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_sorted_insert_table_core
// Sorted table of (tag, key) entries kept in descending key order.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake        Payload
//   in_      input      valid / stall    tksi_pkg::in_item_t
//   out_     output     valid / stall    tksi_pkg::out_item_t
//   cfg_     input      valid / ready    max_entries, 5 bits
//
// Each item is first captured; then all cells compare against the new key in
// parallel and shift in a single update.
// The result sits in an output register, so a new item is taken while it waits.
// A stalled result holds the update cycle until the output register frees.
// Reset clears the entry count and sets the limit to ten; entry contents
// are undefined until written.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_table_core #(
  parameter int CAPACITY = tksi_pkg::CAPACITY_DEF,
  parameter int TAG_BITS = tksi_pkg::TAG_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  tksi_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output tksi_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tksi_pkg::CNT_W-1:0]  cfg_data
);

  tksi_pkg::tksi_cmd_t cmd;

  assign cfg_ready = 1'b1;

  tksi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  tksi_dpath #(
    .CAPACITY (CAPACITY),
    .TAG_BITS (TAG_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule
